@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked at every rising clock edge outside reset
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ design/pbo_pkg.sv @@
// ----------------------------------------------------------------------------
// pbo_pkg
// shared types, codes and the sine table function of the oscillator voice
// ----------------------------------------------------------------------------
`default_nettype none

package pbo_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AM_EN    = 1'b1;

    localparam logic [1:0] WAVE_OFF  = 2'd0;
    localparam logic [1:0] WAVE_SINE = 2'd1;
    localparam logic [1:0] WAVE_SAW  = 2'd2;

    // post-division datapath stages
    localparam logic [2:0] STG_SAW  = 3'd0;
    localparam logic [2:0] STG_Y    = 3'd1;
    localparam logic [2:0] STG_AMP  = 3'd2;
    localparam logic [2:0] STG_MONO = 3'd3;
    localparam logic [2:0] STG_PAN  = 3'd4;

    localparam int DIV_STEPS = 16;

    // one in q30 for the sine table polynomial
    localparam longint SINE_Q30 = longint'(1) <<< 30;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       stage_en;
        logic [2:0] stage;
    } t_dp_cmd;

    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        logic signed [15:0] r;
        if (v > 24'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -24'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

    // sine table entry in 17-bit q2.15, quarter-wave odd polynomial in q30
    // products truncate towards zero, so the q30 scaling stays a division
    function automatic logic signed [16:0] sine_entry(input int idx, input int depth);
        longint a32;
        longint quad;
        longint x;
        longint x2;
        longint p;
        longint y;
        a32  = longint'(idx) <<< (32 - $clog2(depth));
        quad = (a32 >>> 30) & 3;
        x    = a32 & (SINE_Q30 - 1);
        if ((quad & 1) != 0) begin
            x = SINE_Q30 - x;
        end
        x2 = (x * x) / SINE_Q30;
        p  = 172272;
        p  = -5026995 + (p * x2) / SINE_Q30;
        p  = 85569306 + (p * x2) / SINE_Q30;
        p  = -693598668 + (p * x2) / SINE_Q30;
        p  = 1686629713 + (p * x2) / SINE_Q30;
        y  = (p * x) / SINE_Q30;
        if (y < 0) begin
            y = -((-y + 16384) >>> 15);
        end else begin
            y = (y + 16384) >>> 15;
        end
        if (y > 32768) begin
            y = 32768;
        end
        if (y < 0) begin
            y = 0;
        end
        if (quad >= 2) begin
            y = -y;
        end
        return 17'(y);
    endfunction

endpackage

`default_nettype wire

@@ design/pbo_if.sv @@
// ----------------------------------------------------------------------------
// pbo_if
// handshake channels: input words, result words and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface pbo_in_if;
    logic               valid;
    logic               ready;
    logic [22:0]        phase_inc;
    logic [15:0]        gain;
    logic [15:0]        envelope;
    logic [15:0]        am_depth;
    logic signed [15:0] am_sample;
    logic [15:0]        left_weight;
    logic [15:0]        right_weight;

    modport source (output valid, phase_inc, gain, envelope, am_depth, am_sample,
                    left_weight, right_weight, input ready);
    modport sink (input valid, phase_inc, gain, envelope, am_depth, am_sample,
                  left_weight, right_weight, output ready);
endinterface

interface pbo_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mono_out;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;

    modport source (output valid, mono_out, left_out, right_out, input ready);
    modport sink (input valid, mono_out, left_out, right_out, output ready);
endinterface

interface pbo_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/pbo_datapath.sv @@
// ----------------------------------------------------------------------------
// pbo_datapath
// phase accumulator, sine rom, blep divider and gain / am / balance chain
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pbo_datapath
    import pbo_pkg::*;
#(
    parameter int PHASE_BITS       = 24,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [22:0]           i_phase_inc,
    input  wire logic [15:0]           i_gain,
    input  wire logic [15:0]           i_envelope,
    input  wire logic [15:0]           i_am_depth,
    input  wire logic signed [15:0]    i_am_sample,
    input  wire logic [15:0]           i_left_weight,
    input  wire logic [15:0]           i_right_weight,
    output logic signed [15:0]         o_mono_out,
    output logic signed [15:0]         o_left_out,
    output logic signed [15:0]         o_right_out
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH);

    logic [1:0]             r_waveform;
    logic                   r_am_en;
    logic [PHASE_BITS-1:0]  r_phase;
    logic [PHASE_BITS-1:0]  r_p;
    logic [PHASE_BITS-1:0]  r_inc;
    logic [PHASE_BITS:0]    r_rem;
    logic [15:0]            r_q;
    logic                   r_blep;
    logic                   r_rise;
    logic signed [16:0]     r_sine;
    logic [17:0]            r_ge;
    logic signed [32:0]     r_fac;
    logic [15:0]            r_lw;
    logic [15:0]            r_rw;
    logic signed [16:0]     r_s;
    logic signed [18:0]     r_y;
    logic signed [35:0]     r_phi;
    logic signed [35:0]     r_plo;
    logic signed [15:0]     r_mono;
    logic signed [15:0]     r_left;
    logic signed [15:0]     r_right;

    logic signed [16:0]     w_rom [SINE_TABLE_DEPTH];
    logic                   w_on;
    logic [PHASE_BITS-1:0]  w_inc;
    logic [PHASE_BITS:0]    w_sum;
    logic [PHASE_BITS:0]    w_one;
    logic                   w_rise;
    logic                   w_fall;
    logic [PHASE_BITS:0]    w_num;
    logic [32:0]            w_gexp;
    logic [16:0]            w_d;
    logic [32:0]            w_dm;
    logic signed [33:0]     w_fac;
    logic                   w_qbit;
    logic [PHASE_BITS:0]    w_rsel;
    logic [16:0]            w_bc;
    logic [33:0]            w_bp;
    logic [16:0]            w_t;
    logic signed [17:0]     w_fix;
    logic signed [17:0]     w_naive;
    logic signed [17:0]     w_saw;
    logic signed [16:0]     w_s;
    logic signed [35:0]     w_sy;
    logic signed [35:0]     w_syr;
    logic signed [52:0]     w_v;
    logic signed [52:0]     w_vr;
    logic signed [32:0]     w_lp;
    logic signed [32:0]     w_rp;
    logic signed [32:0]     w_lpr;
    logic signed [32:0]     w_rpr;

    for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
        assign w_rom[gi] = sine_entry(gi, SINE_TABLE_DEPTH);
    end

    assign w_on = (r_waveform == WAVE_SINE) || (r_waveform == WAVE_SAW);

    // blep region and divider numerator from the phase before the step
    assign w_inc  = PHASE_BITS'(i_phase_inc);
    assign w_sum  = {1'b0, r_phase} + {1'b0, w_inc};
    assign w_one  = {1'b1, {PHASE_BITS{1'b0}}};
    assign w_rise = r_phase < w_inc;
    assign w_fall = (w_inc != '0) && w_sum[PHASE_BITS];
    assign w_num  = w_rise ? {1'b0, r_phase} : (w_one - {1'b0, r_phase});

    assign w_gexp = 33'(i_gain * i_envelope) + 33'd16384;
    assign w_d    = r_am_en ? 17'(18'sd32768 - 18'(i_am_sample)) : 17'd0;
    assign w_dm   = 33'(i_am_depth * w_d);
    assign w_fac  = $signed({2'b00, 32'h8000_0000}) - $signed({1'b0, w_dm});

    // restoring divider, one quotient bit a cycle
    assign w_qbit = r_rem >= {1'b0, r_inc};
    assign w_rsel = w_qbit ? (r_rem - {1'b0, r_inc}) : r_rem;

    // saw with two-point correction
    assign w_bc    = 17'(18'd65536 - 18'(r_q));
    assign w_bp    = 34'(w_bc * r_q);
    assign w_t     = 17'(w_bp >> 15);
    assign w_naive = $signed({2'b00, r_p[PHASE_BITS-1 -: 16]}) - 18'sd32768;
    always_comb begin
        if (!r_blep) begin
            w_fix = '0;
        end else if (r_rise) begin
            w_fix = $signed({1'b0, w_t}) - 18'sd32768;
        end else begin
            w_fix = 18'sd32768 - $signed({1'b0, w_t});
        end
        w_saw = w_naive - w_fix;
        if (r_waveform != WAVE_SAW) begin
            w_s = r_sine;
        end else if (w_saw > 18'sd32768) begin
            w_s = 17'sd32768;
        end else if (w_saw < -18'sd32768) begin
            w_s = -17'sd32768;
        end else begin
            w_s = 17'(w_saw);
        end
    end

    // rounding adds half less one for negative values: ties go away from zero
    assign w_sy  = r_s * $signed({1'b0, r_ge});
    assign w_syr = w_sy + $signed(36'd16384) - $signed({35'd0, w_sy[35]});
    assign w_v   = (53'(r_phi) <<< 16) + 53'(r_plo);
    assign w_vr  = w_v + $signed(53'h4000_0000) - $signed({52'd0, w_v[52]});
    assign w_lp  = r_mono * $signed({1'b0, r_lw});
    assign w_rp  = r_mono * $signed({1'b0, r_rw});
    assign w_lpr = w_lp + $signed(33'd16384) - $signed({32'd0, w_lp[32]});
    assign w_rpr = w_rp + $signed(33'd16384) - $signed({32'd0, w_rp[32]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform <= WAVE_OFF;
            r_am_en    <= 1'b0;
            r_phase    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WAVEFORM: r_waveform <= i_cfg_data;
                    CFG_AM_EN:    r_am_en    <= i_cfg_data[0];
                    default:      r_am_en    <= r_am_en;
                endcase
            end
            if (i_cmd.stage_en && (i_cmd.stage == STG_PAN) && w_on) begin
                r_phase <= r_p + r_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p    <= r_phase;
            r_inc  <= w_inc;
            r_rem  <= w_num;
            r_q    <= '0;
            r_blep <= w_rise || w_fall;
            r_rise <= w_rise;
            r_sine <= w_rom[r_phase[PHASE_BITS-1 -: AW]];
            r_ge   <= 18'(w_gexp >> 15);
            r_fac  <= 33'(w_fac);
            r_lw   <= i_left_weight;
            r_rw   <= i_right_weight;
        end
        if (i_cmd.div_step) begin
            r_rem <= {w_rsel[PHASE_BITS-1:0], 1'b0};
            r_q   <= {r_q[14:0], w_qbit};
        end
        if (i_cmd.stage_en) begin
            case (i_cmd.stage)
                STG_SAW:  r_s <= w_s;
                STG_Y:    r_y <= 19'(w_syr >>> 15);
                STG_AMP: begin
                    r_phi <= r_y * $signed(r_fac[32:16]);
                    r_plo <= r_y * $signed({1'b0, r_fac[15:0]});
                end
                STG_MONO: r_mono <= sat16(24'(w_vr >>> 31));
                STG_PAN: begin
                    if (w_on) begin
                        r_left  <= sat16(24'(w_lpr >>> 15));
                        r_right <= sat16(24'(w_rpr >>> 15));
                    end else begin
                        r_mono  <= '0;
                        r_left  <= '0;
                        r_right <= '0;
                    end
                end
                default: r_s <= r_s;
            endcase
        end
    end

    assign o_mono_out  = r_mono;
    assign o_left_out  = r_left;
    assign o_right_out = r_right;

    `ASSERT_SYNC(a_phase_hold_off, i_clk, i_rst_n, (i_cmd.stage_en && (i_cmd.stage == STG_PAN) && !w_on && !i_cfg_we) |=> $stable(r_phase), "phase moved with waveform off")
    `ASSERT_SYNC(a_rem_bound, i_clk, i_rst_n, (r_blep && i_cmd.div_step) |-> (r_rem < {r_inc, 1'b0}), "divider remainder out of range")

endmodule

`default_nettype wire

@@ design/pbo_ctrl.sv @@
// ----------------------------------------------------------------------------
// pbo_ctrl
// sequencer: load, sixteen divide steps, five arithmetic stages, result hold
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pbo_ctrl
    import pbo_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_dp_cmd   o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_POST = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic [3:0] r_cnt;
    logic [3:0] n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == 4'(DIV_STEPS - 1)) begin
                    n_state = ST_POST;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_POST: begin
                if (r_cnt == {1'b0, STG_PAN}) begin
                    n_state = ST_OUT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready      = r_state == ST_IDLE;
    assign o_out_valid     = r_state == ST_OUT;
    assign o_cmd.load      = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.div_step  = r_state == ST_DIV;
    assign o_cmd.stage_en  = r_state == ST_POST;
    assign o_cmd.stage     = r_cnt[2:0];

    `ASSERT_SYNC(a_no_overlap, i_clk, i_rst_n, !(o_in_ready && o_out_valid), "input taken while result pending")
    `ASSERT_SYNC(a_accept_starts, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> ((r_state == ST_DIV) && (r_cnt == 4'd0)), "accepted word did not start divide")
    `ASSERT_SYNC(a_div_len, i_clk, i_rst_n, ((r_state == ST_DIV) && (r_cnt == 4'(DIV_STEPS - 1))) |=> ((r_state == ST_POST) && (r_cnt == 4'd0)), "divide did not hand over")

endmodule

`default_nettype wire

@@ design/polyblep_oscillator_am_voice_top.sv @@
// ----------------------------------------------------------------------------
// polyblep_oscillator_am_voice_top
// sine / polyblep saw voice with gain, envelope, ring am and balance
// ----------------------------------------------------------------------------
//  channel   dir  content
//  i_in      in   phase_inc, gain, envelope, am_depth, am_sample, weights
//  o_out     out  mono_out, left_out, right_out
//  i_cfg     in   index 0 waveform, index 1 am source enable
//
//  a word is accepted only when idle; 16 steps of the restoring blep divider
//  and 5 arithmetic stages follow, then the result is held valid until it is
//  taken; the next word can be accepted in the cycle after the result is taken,
//  so words never overlap and input is refused meanwhile.
//  reset is synchronous, active low, and clears phase and both registers.
//  register writes are always accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module polyblep_oscillator_am_voice_top
    import pbo_pkg::*;
#(
    parameter int PHASE_BITS       = 24,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    pbo_in_if.sink    i_in,
    pbo_out_if.source o_out,
    pbo_cfg_if.sink   i_cfg
);

    t_dp_cmd w_cmd;
    logic    w_in_ready;
    logic    w_out_valid;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    pbo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    pbo_datapath #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_phase_inc    (i_in.phase_inc),
        .i_gain         (i_in.gain),
        .i_envelope     (i_in.envelope),
        .i_am_depth     (i_in.am_depth),
        .i_am_sample    (i_in.am_sample),
        .i_left_weight  (i_in.left_weight),
        .i_right_weight (i_in.right_weight),
        .o_mono_out     (o_out.mono_out),
        .o_left_out     (o_out.left_out),
        .o_right_out    (o_out.right_out)
    );

endmodule

`default_nettype wire
